@@ src/icl_pkg.sv @@
// Shared types, constants and helper functions for the ICCID reply Luhn checker.
package icl_pkg;

  localparam int LINE_LEN   = 64;
  localparam int POS_W      = $clog2(LINE_LEN + 1);
  localparam int COUNT_W    = 7;
  localparam int PREFIX_LEN = 8;
  localparam int PREFIX_W   = $clog2(PREFIX_LEN);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] DIGIT_MAX  = 7'd127;
  localparam logic [COUNT_W-1:0] ICCID_MIN  = 7'd18;
  localparam logic [COUNT_W-1:0] ICCID_MAX  = 7'd22;
  localparam logic [3:0]         LUHN_FIRST = 4'd8;
  localparam logic [3:0]         LUHN_SECOND = 4'd9;
  localparam logic [3:0]         RADIX      = 4'd10;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic REG_CHECK_ICCID = 1'b0;

  typedef enum logic [1:0] {
    CLS_UNDECIDED = 2'd0,
    CLS_IGNORED   = 2'd1,
    CLS_PLAIN     = 2'd2,
    CLS_PREFIXED  = 2'd3
  } line_class_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_A    = 2'd1,
    PEND_PLUS = 2'd2
  } pend_kind_t;

  typedef enum logic [1:0] {
    VERDICT_IGNORED  = 2'd0,
    VERDICT_ACCEPTED = 2'd1,
    VERDICT_REJECTED = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] line_char;
    logic       line_last;
  } item_t;

  typedef struct packed {
    verdict_t             verdict;
    logic [COUNT_W-1:0]   digit_total;
  } result_t;

  typedef struct packed {
    logic fire;
    logic check_iccid;
  } scan_ctrl_t;

  function automatic logic [7:0] prefix_char(input logic [PREFIX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h43;
      3'd3:    c = 8'h43;
      3'd4:    c = 8'h49;
      3'd5:    c = 8'h44;
      3'd6:    c = 8'h3A;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, RADIX}) begin
      s = s - {1'b0, RADIX};
    end
    return s[3:0];
  endfunction

endpackage

@@ src/icl_scan.sv @@
// Line classifier, leading digit counter and dual-parity Luhn sums for one reply line.
module icl_scan (
  input  logic              clk,
  input  logic              rst,
  input  icl_pkg::item_t    item,
  input  icl_pkg::scan_ctrl_t ctrl,
  output icl_pkg::result_t  result,
  output logic              line_idle
);

  logic [icl_pkg::POS_W-1:0]   pos, pos_next;
  icl_pkg::line_class_t        cls, cls_next;
  icl_pkg::pend_kind_t         pend, pend_next;
  logic [icl_pkg::COUNT_W-1:0] cnt, cnt_next;
  logic [3:0]                  sum_even, sum_even_next;
  logic [3:0]                  sum_odd, sum_odd_next;
  logic                        ended, ended_next;
  logic                        first_eight, first_eight_next;
  logic                        second_nine, second_nine_next;

  logic                        do_feed;
  logic                        is_digit;
  logic [3:0]                  d;
  logic [4:0]                  dbl;
  logic [3:0]                  dd;
  logic [7:0]                  ch;
  logic [7:0]                  ch_off;
  icl_pkg::line_class_t        cls_final;
  logic [3:0]                  sum_sel;
  logic                        luhn_ok;

  assign ch       = item.line_char;
  assign is_digit = (ch >= icl_pkg::CHAR_ZERO) && (ch <= icl_pkg::CHAR_NINE);
  assign ch_off   = ch - icl_pkg::CHAR_ZERO;
  assign d        = ch_off[3:0];
  assign dbl      = {d, 1'b0};
  assign dd       = (d < 4'd5) ? dbl[3:0] : 4'(dbl - 5'd9);

  always_comb begin
    pos_next         = pos;
    cls_next         = cls;
    pend_next        = pend;
    cnt_next         = cnt;
    sum_even_next    = sum_even;
    sum_odd_next     = sum_odd;
    ended_next       = ended;
    first_eight_next = first_eight;
    second_nine_next = second_nine;
    do_feed          = 1'b0;

    if (pos < icl_pkg::POS_W'(icl_pkg::LINE_LEN)) begin
      pos_next = pos + 1'b1;
      case (cls) inside
        icl_pkg::CLS_IGNORED: begin
        end
        icl_pkg::CLS_PLAIN, icl_pkg::CLS_PREFIXED: begin
          do_feed = 1'b1;
        end
        default: begin
          if (pos == '0) begin
            if (ch == icl_pkg::CHAR_CR) begin
              cls_next = icl_pkg::CLS_IGNORED;
            end else if (ch == icl_pkg::CHAR_A) begin
              pend_next  = icl_pkg::PEND_A;
              ended_next = 1'b1;
            end else if (ch == icl_pkg::CHAR_PLUS) begin
              pend_next = icl_pkg::PEND_PLUS;
            end else begin
              cls_next = icl_pkg::CLS_PLAIN;
              do_feed  = 1'b1;
            end
          end else if (pend == icl_pkg::PEND_A) begin
            cls_next = (ch == icl_pkg::CHAR_T) ? icl_pkg::CLS_IGNORED : icl_pkg::CLS_PLAIN;
          end else if ((pos < icl_pkg::POS_W'(icl_pkg::PREFIX_LEN)) &&
                       (ch == icl_pkg::prefix_char(pos[icl_pkg::PREFIX_W-1:0]))) begin
            if (pos == icl_pkg::POS_W'(icl_pkg::PREFIX_LEN - 1)) begin
              cls_next = icl_pkg::CLS_PREFIXED;
            end
          end else begin
            cls_next = icl_pkg::CLS_IGNORED;
          end
        end
      endcase
    end

    if (do_feed && !ended) begin
      if (!is_digit) begin
        ended_next = 1'b1;
      end else if (cnt != icl_pkg::DIGIT_MAX) begin
        if (cnt == 7'd0) begin
          first_eight_next = (d == icl_pkg::LUHN_FIRST);
        end
        if (cnt == 7'd1) begin
          second_nine_next = (d == icl_pkg::LUHN_SECOND);
        end
        if (!cnt[0]) begin
          sum_even_next = icl_pkg::add_mod10(sum_even, dd);
          sum_odd_next  = icl_pkg::add_mod10(sum_odd, d);
        end else begin
          sum_even_next = icl_pkg::add_mod10(sum_even, d);
          sum_odd_next  = icl_pkg::add_mod10(sum_odd, dd);
        end
        cnt_next = cnt + 1'b1;
      end
    end
  end

  always_comb begin
    cls_final = cls_next;
    if (cls_next == icl_pkg::CLS_UNDECIDED) begin
      cls_final = (pend_next == icl_pkg::PEND_A) ? icl_pkg::CLS_PLAIN : icl_pkg::CLS_IGNORED;
    end
    sum_sel = cnt_next[0] ? sum_odd_next : sum_even_next;
    luhn_ok = (cnt_next >= icl_pkg::ICCID_MIN) && (cnt_next <= icl_pkg::ICCID_MAX) &&
              (sum_sel == 4'd0) && first_eight_next && second_nine_next;
    if (cls_final == icl_pkg::CLS_IGNORED) begin
      result.verdict     = icl_pkg::VERDICT_IGNORED;
      result.digit_total = '0;
    end else begin
      result.digit_total = cnt_next;
      if (ctrl.check_iccid && !luhn_ok) begin
        result.verdict = icl_pkg::VERDICT_REJECTED;
      end else begin
        result.verdict = icl_pkg::VERDICT_ACCEPTED;
      end
    end
  end

  assign line_idle = (pos == '0);

  always_ff @(posedge clk) begin
    if (rst || (ctrl.fire && item.line_last)) begin
      pos         <= '0;
      cls         <= icl_pkg::CLS_UNDECIDED;
      pend        <= icl_pkg::PEND_NONE;
      cnt         <= '0;
      sum_even    <= '0;
      sum_odd     <= '0;
      ended       <= 1'b0;
      first_eight <= 1'b0;
      second_nine <= 1'b0;
    end else if (ctrl.fire) begin
      pos         <= pos_next;
      cls         <= cls_next;
      pend        <= pend_next;
      cnt         <= cnt_next;
      sum_even    <= sum_even_next;
      sum_odd     <= sum_odd_next;
      ended       <= ended_next;
      first_eight <= first_eight_next;
      second_nine <= second_nine_next;
    end
  end

endmodule

@@ src/iccid_reply_luhn_checker.sv @@
// Top level: input register, line scanner, result register and APB register port.
// Result: out_valid is set at the edge that takes a line's last item out of the input
// register.
// Throughput: one item per cycle; the input stalls only while a last item waits on a
// full, stalled result register.
// Reset: synchronous rst clears line state, valid flags and check_iccid.
module iccid_reply_luhn_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      line_char,
  input  logic                            line_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      verdict,
  output logic [icl_pkg::COUNT_W-1:0]     digit_total,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [icl_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [icl_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [icl_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic                 check_iccid;
  logic                 s_valid;
  icl_pkg::item_t       s_item;
  logic                 s_fire;
  icl_pkg::scan_ctrl_t  scan_ctrl;
  icl_pkg::result_t     scan_result;
  logic                 line_idle;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_iccid <= 1'b0;
    end else if (cfg_write && (paddr[icl_pkg::CFG_ADDR_W-1] == icl_pkg::REG_CHECK_ICCID)) begin
      check_iccid <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[icl_pkg::CFG_ADDR_W-1] == icl_pkg::REG_CHECK_ICCID) begin
      prdata[0] = check_iccid;
    end
  end

  assign s_fire   = s_valid && (!s_item.line_last || !out_valid || !out_stall);
  assign in_stall = s_valid && !s_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_item.line_char <= line_char;
      s_item.line_last <= line_last;
    end
  end

  assign scan_ctrl.fire        = s_fire;
  assign scan_ctrl.check_iccid = check_iccid;

  icl_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .item      (s_item),
    .ctrl      (scan_ctrl),
    .result    (scan_result),
    .line_idle (line_idle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire && s_item.line_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_item.line_last) begin
      verdict     <= scan_result.verdict;
      digit_total <= scan_result.digit_total;
    end
  end

  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_item.line_last |=> line_idle)
    else $error("line state not cleared after last item");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s_valid && s_item.line_last && out_valid && out_stall))
    else $error("input stalled without a waiting verdict");

  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict == icl_pkg::VERDICT_IGNORED) |-> (digit_total == '0))
    else $error("ignored line carries a digit count");

  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s_fire && s_item.line_last))
    else $error("verdict without a finished line");

endmodule

@@ dv/iccid_reply_luhn_checker_tb.sv @@
// Testbench for iccid_reply_luhn_checker: line sorting, Luhn verdicts, idling and backpressure.
module iccid_reply_luhn_checker_tb;

  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 600;
  localparam logic [8*icl_pkg::PREFIX_LEN-1:0] ICCID_HEAD = "+ICCID: ";

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;
  typedef enum int {FAULT_NONE, FAULT_CHECK, FAULT_FIRST, FAULT_SECOND} luhn_fault_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     line_char;
  logic                           line_last;
  logic                           out_valid;
  logic                           out_stall;
  logic [1:0]                     verdict;
  logic [icl_pkg::COUNT_W-1:0]    digit_total;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [icl_pkg::CFG_ADDR_W-1:0] paddr;
  logic [icl_pkg::CFG_DATA_W-1:0] pwdata;
  logic [icl_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  iccid_reply_luhn_checker u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .line_char   (line_char),
    .line_last   (line_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .verdict     (verdict),
    .digit_total (digit_total),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // line scanner state kept by the testbench
  logic                 check_reg = 1'b0;
  int                   lc_pos = 0;
  icl_pkg::line_class_t lc_class = icl_pkg::CLS_UNDECIDED;
  icl_pkg::pend_kind_t  lc_pend = icl_pkg::PEND_NONE;
  int                   lc_count = 0;
  int                   lc_sum_even = 0;
  int                   lc_sum_odd = 0;
  bit                   lc_ended = 1'b0;
  bit                   lc_first8 = 1'b0;
  bit                   lc_second9 = 1'b0;

  icl_pkg::result_t     verdict_q[$];
  icl_pkg::result_t     due;
  logic [7:0]           line_buf[$];

  int          err_count = 0;
  int          items_sent = 0;
  int          lines_sent = 0;
  int          n_accepted = 0;
  int          n_rejected = 0;
  int          n_ignored = 0;
  int          in_held_cycles = 0;
  int          quiet_cycles = 0;
  int          rx_tick = 0;

  bit          idle_en = 1'b0;
  int          max_gap = 4;
  int          burst_left = 0;
  rx_mode_t    rx_mode = RX_FREE;
  bit          hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] head_char(input int p);
    return ICCID_HEAD[8*(icl_pkg::PREFIX_LEN-1-p) +: 8];
  endfunction

  function automatic int luhn_double(input int d);
    return (d < 5) ? 2 * d : 2 * d - 9;
  endfunction

  function automatic void clear_line();
    lc_pos = 0;
    lc_class = icl_pkg::CLS_UNDECIDED;
    lc_pend = icl_pkg::PEND_NONE;
    lc_count = 0;
    lc_sum_even = 0;
    lc_sum_odd = 0;
    lc_ended = 1'b0;
    lc_first8 = 1'b0;
    lc_second9 = 1'b0;
  endfunction

  function automatic void fold_digit(input logic [7:0] c);
    int d;
    if (lc_ended) return;
    if (c < icl_pkg::CHAR_ZERO || c > icl_pkg::CHAR_NINE) begin
      lc_ended = 1'b1;
      return;
    end
    if (lc_count >= icl_pkg::DIGIT_MAX) return;
    d = c - icl_pkg::CHAR_ZERO;
    if (lc_count == 0) lc_first8 = (d == icl_pkg::LUHN_FIRST);
    if (lc_count == 1) lc_second9 = (d == icl_pkg::LUHN_SECOND);
    if (lc_count % 2 == 0) begin
      lc_sum_even = (lc_sum_even + luhn_double(d)) % icl_pkg::RADIX;
      lc_sum_odd  = (lc_sum_odd + d) % icl_pkg::RADIX;
    end else begin
      lc_sum_even = (lc_sum_even + d) % icl_pkg::RADIX;
      lc_sum_odd  = (lc_sum_odd + luhn_double(d)) % icl_pkg::RADIX;
    end
    lc_count++;
  endfunction

  function automatic void sort_char(input logic [7:0] c);
    if (lc_class == icl_pkg::CLS_IGNORED) return;
    if (lc_class == icl_pkg::CLS_PLAIN || lc_class == icl_pkg::CLS_PREFIXED) begin
      fold_digit(c);
      return;
    end
    if (lc_pos == 0) begin
      if (c == icl_pkg::CHAR_CR) begin
        lc_class = icl_pkg::CLS_IGNORED;
      end else if (c == icl_pkg::CHAR_A) begin
        lc_pend = icl_pkg::PEND_A;
        lc_ended = 1'b1;
      end else if (c == icl_pkg::CHAR_PLUS) begin
        lc_pend = icl_pkg::PEND_PLUS;
      end else begin
        lc_class = icl_pkg::CLS_PLAIN;
        fold_digit(c);
      end
      return;
    end
    if (lc_pend == icl_pkg::PEND_A) begin
      lc_class = (c == icl_pkg::CHAR_T) ? icl_pkg::CLS_IGNORED : icl_pkg::CLS_PLAIN;
      return;
    end
    if (lc_pos < icl_pkg::PREFIX_LEN && c == head_char(lc_pos)) begin
      if (lc_pos == icl_pkg::PREFIX_LEN - 1) lc_class = icl_pkg::CLS_PREFIXED;
    end else begin
      lc_class = icl_pkg::CLS_IGNORED;
    end
  endfunction

  function automatic void take_item(input logic [7:0] c, input logic last);
    icl_pkg::line_class_t cls;
    int                   sum;
    icl_pkg::result_t     r;
    if (lc_pos < icl_pkg::LINE_LEN) begin
      sort_char(c);
      lc_pos++;
    end
    if (!last) return;
    cls = lc_class;
    if (cls == icl_pkg::CLS_UNDECIDED) begin
      cls = (lc_pend == icl_pkg::PEND_A) ? icl_pkg::CLS_PLAIN : icl_pkg::CLS_IGNORED;
    end
    if (cls == icl_pkg::CLS_IGNORED) begin
      r.verdict = icl_pkg::VERDICT_IGNORED;
      r.digit_total = '0;
    end else begin
      r.digit_total = lc_count[icl_pkg::COUNT_W-1:0];
      if (check_reg) begin
        sum = (lc_count % 2) ? lc_sum_odd : lc_sum_even;
        r.verdict = (lc_count >= icl_pkg::ICCID_MIN && lc_count <= icl_pkg::ICCID_MAX &&
                     sum == 0 && lc_first8 && lc_second9) ?
                    icl_pkg::VERDICT_ACCEPTED : icl_pkg::VERDICT_REJECTED;
      end else begin
        r.verdict = icl_pkg::VERDICT_ACCEPTED;
      end
    end
    verdict_q.push_back(r);
    clear_line();
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    err_count++;
    if (err_count <= 10) begin
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) take_item(line_char, line_last);
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          note_mismatch("result with nothing pending, verdict", -1, verdict);
        end else begin
          due = verdict_q.pop_front();
          if (due.verdict != verdict) note_mismatch("verdict", due.verdict, verdict);
          if (due.digit_total != digit_total) begin
            note_mismatch("digit_total", due.digit_total, digit_total);
          end
          case (due.verdict)
            icl_pkg::VERDICT_ACCEPTED: n_accepted++;
            icl_pkg::VERDICT_REJECTED: n_rejected++;
            default:                   n_ignored++;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_stall) in_held_cycles++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("iccid_reply_luhn_checker_tb: errors");
      $finish;
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      rx_tick++;
      case (rx_mode)
        RX_FREE:   out_stall <= 1'b0;
        RX_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
        default:   out_stall <= ((rx_tick % 7) < 3);
      endcase
    end
  end

  task automatic send_item(input logic [7:0] c, input logic last);
    int gap;
    if (idle_en && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, max_gap);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid  <= 1'b1;
    line_char <= c;
    line_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_line();
    int k;
    for (k = 0; k < line_buf.size(); k++) send_item(line_buf[k], k == line_buf.size() - 1);
    line_buf.delete();
    lines_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_check_iccid(input logic v);
    logic [icl_pkg::CFG_DATA_W-1:0] junk;
    junk = $urandom;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {icl_pkg::REG_CHECK_ICCID, 2'b00};
    pwdata  <= {junk[icl_pkg::CFG_DATA_W-1:1], v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_reg = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(icl_pkg::CFG_DATA_W-1){1'b0}}, v}) begin
      note_mismatch("check_iccid readback", v, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic put_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
  endtask

  task automatic put_noise(input int max_len);
    int k, n;
    n = $urandom_range(0, max_len);
    for (k = 0; k < n; k++) line_buf.push_back($urandom_range(0, 255));
  endtask

  task automatic put_digits(input int n);
    int k;
    for (k = 0; k < n; k++) line_buf.push_back(icl_pkg::CHAR_ZERO + $urandom_range(0, 9));
  endtask

  task automatic put_tail();
    case ($urandom_range(0, 3))
      0:       line_buf.push_back(icl_pkg::CHAR_CR);
      1:       put_noise(3);
      default: ;
    endcase
  endtask

  // n digits whose Luhn sum is zero unless a check-digit fault is asked for
  task automatic put_iccid(input int n, input luhn_fault_t fault);
    int d[$];
    int k, s, v;
    d.push_back(icl_pkg::LUHN_FIRST);
    d.push_back(icl_pkg::LUHN_SECOND);
    if (fault == FAULT_FIRST) begin
      v = $urandom_range(0, 8);
      d[0] = (v == icl_pkg::LUHN_FIRST) ? 9 : v;
    end
    if (fault == FAULT_SECOND) d[1] = $urandom_range(0, 8);
    for (k = 2; k < n - 1; k++) d.push_back($urandom_range(0, 9));
    s = 0;
    for (k = 0; k < n - 1; k++) s += ((n - 1 - k) % 2) ? luhn_double(d[k]) : d[k];
    d.push_back((icl_pkg::RADIX - s % icl_pkg::RADIX) % icl_pkg::RADIX);
    if (fault == FAULT_CHECK) d[n-1] = (d[n-1] + $urandom_range(1, 9)) % icl_pkg::RADIX;
    for (k = 0; k < n; k++) line_buf.push_back(icl_pkg::CHAR_ZERO + d[k]);
  endtask

  task automatic put_random_line();
    int k, n;
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        put_text("+ICCID: ");
        put_iccid($urandom_range(18, 22), FAULT_NONE);
        put_tail();
      end
      3: begin
        put_iccid($urandom_range(16, 24), luhn_fault_t'($urandom_range(0, 3)));
        put_tail();
      end
      4: begin
        put_text("+ICCID: ");
        put_iccid($urandom_range(17, 23), luhn_fault_t'($urandom_range(0, 3)));
        put_tail();
      end
      5: begin
        put_text("AT");
        put_noise(8);
      end
      6: begin
        line_buf.push_back(icl_pkg::CHAR_CR);
        put_noise(4);
      end
      7: begin
        n = $urandom_range(1, icl_pkg::PREFIX_LEN);
        for (k = 0; k < n; k++) line_buf.push_back(head_char(k));
        if ($urandom_range(0, 1)) line_buf[n-1] = $urandom_range(0, 255);
        if ($urandom_range(0, 1)) put_digits($urandom_range(0, 22));
      end
      8: begin
        line_buf.push_back(icl_pkg::CHAR_A);
        put_noise(5);
      end
      9: begin
        line_buf.push_back($urandom_range(0, 255));
        put_noise(20);
      end
      10: begin
        put_digits($urandom_range(1, 12));
        put_noise(6);
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1)) put_text("+ICCID: ");
          put_digits($urandom_range(56, 80));
          put_noise(4);
        end else begin
          put_digits($urandom_range(1, 30));
        end
      end
    endcase
  endtask

  task automatic test_line_sorting();
    set_check_iccid(1'b0);
    put_text("\r");  send_line();
    put_text("AT");  send_line();
    put_text("A");   send_line();
    put_text("A7");  send_line();
    put_text("+");   send_line();
    put_text("+IC"); send_line();
    put_text("+CSQ"); send_line();
    put_text("+ICCID: 4x"); send_line();
    line_buf.push_back(8'h00);
    put_text("5");   send_line();
    put_text("/9:"); send_line();
    line_buf.push_back(8'hFF);
    send_line();
  endtask

  task automatic test_iccid_checks();
    int n;
    set_check_iccid(1'b1);
    for (n = icl_pkg::ICCID_MIN - 1; n <= icl_pkg::ICCID_MAX + 1; n++) begin
      if (n % 2) put_text("+ICCID: ");
      put_iccid(n, FAULT_NONE);
      send_line();
    end
    put_iccid(20, FAULT_CHECK);  send_line();
    put_iccid(19, FAULT_FIRST);  send_line();
    put_text("+ICCID: ");
    put_iccid(21, FAULT_SECOND); send_line();
    put_text("+ICCID: ");        send_line();
  endtask

  task automatic test_overlong_lines();
    set_check_iccid(1'b0);
    put_digits(icl_pkg::LINE_LEN + 6);
    send_line();
    put_text("+ICCID: ");
    put_digits(icl_pkg::LINE_LEN - 2);
    put_text("x");
    send_line();
    set_check_iccid(1'b1);
    put_iccid(20, FAULT_NONE);
    put_digits(icl_pkg::LINE_LEN);
    send_line();
  endtask

  task automatic test_random_lines();
    int phase, start;
    for (phase = 0; phase < 6; phase++) begin
      set_check_iccid(phase % 2 == 0);
      rx_mode = rx_mode_t'(phase % 3);
      idle_en = (phase != 2);
      max_gap = (phase == 5) ? 20 : 4;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS / 6) begin
        put_random_line();
        send_line();
      end
    end
  endtask

  task automatic test_backpressure();
    int start;
    set_check_iccid(1'b1);
    rx_mode = RX_FREE;
    idle_en = 1'b0;
    hold_req = 1'b1;
    start = items_sent;
    while (items_sent - start < 150) begin
      put_random_line();
      send_line();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    line_char <= '0;
    line_last <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_line_sorting();
    test_iccid_checks();
    test_overlong_lines();
    test_random_lines();
    test_backpressure();
    wait_idle();
    $display("covered %0d lines in %0d items: %0d accepted, %0d rejected, %0d ignored",
             lines_sent, items_sent, n_accepted, n_rejected, n_ignored);
    $display("input held off for %0d cycles, %0d mismatches", in_held_cycles, err_count);
    if (err_count == 0) begin
      $display("iccid_reply_luhn_checker_tb: clean");
    end else begin
      $display("iccid_reply_luhn_checker_tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/icl_pkg.sv
src/icl_scan.sv
src/iccid_reply_luhn_checker.sv
dv/iccid_reply_luhn_checker_tb.sv
